[src/tkas_pkg.sv]
// Shared constants, types and order-key function for the top-k select block.
package tkas_pkg;

   // Capacity of the ranked list and of one slice
   localparam int MAX_KEEP  = 16;
   localparam int MAX_SLICE = 1024;

   // Derived widths
   localparam int WORD_W  = 32;
   localparam int IDX_W   = (MAX_SLICE > 1) ? $clog2(MAX_SLICE) : 1;
   localparam int CNT_W   = $clog2(MAX_SLICE + 1);
   localparam int KEEP_W  = $clog2(MAX_KEEP + 1);
   localparam int POS_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int REQ_W   = 32;
   localparam int RSP_RAW = WORD_W + IDX_W;
   localparam int RSP_W   = ((RSP_RAW + 7) / 8) * 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int KEEP_CFG_W = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIND_LARGEST = 2'd0,
      CSR_KEEP_COUNT   = 2'd1,
      CSR_FLOAT_ORDER  = 2'd2
   } csr_reg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // element beat taken
      logic close;    // element beat carried the last mark
      logic advance;  // result beat taken
   } tkas_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_rank; // current result is the final one of the slice
   } tkas_stat_type;

   // Map a word to an unsigned key whose order matches the number order
   function automatic logic [WORD_W-1:0] order_key(input logic [WORD_W-1:0] w,
                                                   input logic float_mode);
      logic [WORD_W-1:0] k;
      begin
         k = w ^ {1'b1, {(WORD_W-1){1'b0}}};
         if (float_mode) begin
            if (w[WORD_W-2:0] == '0) begin
               k = {1'b1, {(WORD_W-1){1'b0}}};
            end else if (w[WORD_W-1]) begin
               k = ~w;
            end
         end
         return k;
      end
   endfunction

endpackage

[src/tkas_ctrl.sv]
// Controller state machine: loads a slice, then walks out its results.
module tkas_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output tkas_pkg::tkas_cmd_type cmd,
   input  tkas_pkg::tkas_stat_type stat
);
   import tkas_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_EMIT);

   // Commands from the handshakes
   assign cmd.accept  = req_tvalid & req_tready;
   assign cmd.close   = req_tvalid & req_tready & req_tlast;
   assign cmd.advance = rsp_tvalid & rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (cmd.close) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cmd.advance && stat.last_rank) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/tkas_dp.sv]
// Datapath: settings, insertion chain of ranked entries, count and emit pointer.
module tkas_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [tkas_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tkas_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic [tkas_pkg::WORD_W-1:0]       sample_word,
   input  tkas_pkg::tkas_cmd_type            cmd,
   output tkas_pkg::tkas_stat_type           stat,
   output logic [tkas_pkg::WORD_W-1:0]       result_value,
   output logic [tkas_pkg::IDX_W-1:0]        result_index
);
   import tkas_pkg::*;

   // Settings
   logic                  find_largest_ff;
   logic [KEEP_CFG_W-1:0] keep_count_ff;
   logic                  float_order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         find_largest_ff <= 1'b1;
         keep_count_ff   <= KEEP_CFG_W'(1);
         float_order_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            CSR_FIND_LARGEST: find_largest_ff <= csr_data[0];
            CSR_KEEP_COUNT:   keep_count_ff   <= csr_data[KEEP_CFG_W-1:0];
            CSR_FLOAT_ORDER:  float_order_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Ranked entries, no reset: only filled positions are ever read
   logic [WORD_W-1:0] value_ff [MAX_KEEP];
   logic [IDX_W-1:0]  index_ff [MAX_KEEP];
   logic [WORD_W-1:0] value_in [MAX_KEEP];
   logic [IDX_W-1:0]  index_in [MAX_KEEP];
   logic              write_en [MAX_KEEP];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KEEP_W-1:0] emit_n_ff, emit_n_in;
   logic [POS_W-1:0]  ptr_ff, ptr_in;

   logic [KEEP_W-1:0] held;
   logic [KEEP_W-1:0] held_after;
   logic [KEEP_W-1:0] keep_eff;
   logic [CNT_W-1:0]  count_next;
   logic              room;
   logic [WORD_W-1:0] key_new;

   assign room    = (count_ff < CNT_W'(MAX_SLICE));
   assign key_new = order_key(sample_word, float_order_ff);
   assign held    = (count_ff < CNT_W'(MAX_KEEP)) ? KEEP_W'(count_ff) : KEEP_W'(MAX_KEEP);

   // Insertion point: first held entry the new element strictly beats, else the first free position
   always_comb begin
      logic beats;
      logic ge_prev;
      logic ge_cur;
      logic [WORD_W-1:0] key_old;
      ge_prev = 1'b0;
      for (int j = 0; j < MAX_KEEP; j++) begin
         key_old = order_key(value_ff[j], float_order_ff);
         beats   = find_largest_ff ? (key_new > key_old) : (key_new < key_old);
         ge_cur  = ge_prev | (KEEP_W'(j) >= held) | beats;
         write_en[j] = cmd.accept & room & ge_cur;
         if (ge_cur && !ge_prev) begin
            value_in[j] = sample_word;
            index_in[j] = count_ff[IDX_W-1:0];
         end else if (j > 0) begin
            value_in[j] = value_ff[(j > 0) ? j - 1 : 0];
            index_in[j] = index_ff[(j > 0) ? j - 1 : 0];
         end else begin
            value_in[j] = value_ff[j];
            index_in[j] = index_ff[j];
         end
         ge_prev = ge_cur;
      end
   end

   for (genvar g = 0; g < MAX_KEEP; g++) begin : g_entry
      always_ff @(posedge clock) begin
         if (write_en[g]) begin
            value_ff[g] <= value_in[g];
            index_ff[g] <= index_in[g];
         end
      end
   end

   // Count after this element and the number of results to send
   assign count_next = room ? count_ff + CNT_W'(1) : count_ff;
   assign held_after = (count_next < CNT_W'(MAX_KEEP)) ? KEEP_W'(count_next)
                                                       : KEEP_W'(MAX_KEEP);

   always_comb begin
      if (keep_count_ff == '0) begin
         keep_eff = KEEP_W'(1);
      end else if (32'(keep_count_ff) > MAX_KEEP) begin
         keep_eff = KEEP_W'(MAX_KEEP);
      end else begin
         keep_eff = KEEP_W'(keep_count_ff);
      end
   end

   always_comb begin
      count_in  = count_ff;
      emit_n_in = emit_n_ff;
      ptr_in    = ptr_ff;
      priority if (cmd.close) begin
         count_in  = '0;
         emit_n_in = (keep_eff < held_after) ? keep_eff : held_after;
         ptr_in    = '0;
      end else if (cmd.accept) begin
         count_in = count_next;
      end else if (cmd.advance) begin
         ptr_in = ptr_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         emit_n_ff <= KEEP_W'(1);
         ptr_ff    <= '0;
      end else begin
         count_ff  <= count_in;
         emit_n_ff <= emit_n_in;
         ptr_ff    <= ptr_in;
      end
   end

   // Result selection
   assign result_value   = value_ff[ptr_ff];
   assign result_index   = index_ff[ptr_ff];
   assign stat.last_rank = ((KEEP_W'(ptr_ff) + KEEP_W'(1)) == emit_n_ff);

endmodule

[src/top_k_arg_select_unit.sv]
// Top level: streaming top-k argmax/argmin selection over one slice.
// The first result beat is valid in the cycle after the beat of the last element.
// Throughput: one element per cycle while loading; then k result beats, one per cycle while rsp_tready is high,
// k = min(keep_count, elements kept), a keep_count of 0 counting as 1; input is held off while results drain.
// The insertion across all kept entries is combinational and registered at once, which sets the load rate.
// Reset (synchronous, active high) clears count, pointer and state, loads register defaults.
module top_k_arg_select_unit (
   input  logic                               clock,
   input  logic                               reset,
   // element channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tkas_pkg::REQ_W-1:0]         req_tdata,  // [31:0] sample_word
   input  logic                               req_tlast,  // last_element
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tkas_pkg::RSP_W-1:0]         rsp_tdata,  // [31:0] result_value, [41:32] result_index
   output logic                               rsp_tlast,  // result_last
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tkas_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tkas_pkg::CSR_DATA_W-1:0]    csr_data
);
   import tkas_pkg::*;

   tkas_cmd_type      cmd;
   tkas_stat_type     stat;
   logic [WORD_W-1:0] result_value;
   logic [IDX_W-1:0]  result_index;

   assign csr_ready = 1'b1;

   tkas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   tkas_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .sample_word  (req_tdata[WORD_W-1:0]),
      .cmd          (cmd),
      .stat         (stat),
      .result_value (result_value),
      .result_index (result_index)
   );

   // Pack result beat
   assign rsp_tdata = RSP_W'({result_index, result_value});
   assign rsp_tlast = stat.last_rank;

   // Loading and draining never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("element and result channels active together");

   // Last element beat starts draining next cycle
   a_close_emit: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("no result after last element");

   // Final result beat returns to loading
   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("not loading after final result");

   // A non-final result beat is followed by another result
   a_drain_more: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("results ended before final mark");

endmodule
